FILE: sv/frame_deframer_crc16_check_macros.svh
// assertion macros for the frame deframer checker
`ifndef FRAME_DEFRAMER_CRC16_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_CRC16_CHECK_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define FDC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication, also checked through reset
`define FDC_ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: sv/fdc_pkg.sv
// types and codes shared by the frame deframer files, and the crc function of the core
package fdc_pkg;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [8:0] POS_MAX = 9'd511;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_topic;
      logic [7:0] declared_length;
      logic [1:0] status;
      logic       truncated;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/frame_deframer_crc16_check.sv
// top level of the framed packet deframer with crc-16 check
//
// input channel req_: one frame byte per item, req_frame_end marks the
// final byte. result channel rsp_: data items (rsp_kind 0) carry the
// declared data bytes, a summary item (rsp_kind 1) closes every frame with
// topic, declared length, status and truncation. rsp_last marks the final
// result caused by one input byte.
// a byte is accepted in the cycle req_valid is high and req_stall is low;
// its results are written into a four-entry result queue at that edge and
// the first one is shown on rsp_ in the next cycle if the queue was empty.
// one byte per cycle while req_stall is low; a byte ending a frame with data
// yields two results, which leave the queue one per cycle unless rsp_stall.
// req_stall rises when fewer than two queue entries are free, so the
// queue never overflows while the receiver holds rsp_stall.
// data bytes leave two bytes behind the input, since the last two frame
// bytes are the crc and are never passed out.
// synchronous reset empties the queue and returns the frame state to the
// start of a frame with the crc at its initial value.
module frame_deframer_crc16_check
   import fdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_topic,
   output logic [7:0] rsp_declared_length,
   output logic [1:0] rsp_status,
   output logic       rsp_truncated,
   output logic       rsp_last
);

   localparam int QDEPTH = 4;

   push_type   push;
   logic       take;
   logic       pop;
   result_type queue_ff [QDEPTH];
   result_type head;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] n_push;

   assign req_stall = (count_ff > 3'd2);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;

   fdc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .frame_end (req_frame_end),
      .push      (push)
   );

   always_comb begin
      n_push    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
      head      = queue_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         queue_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         queue_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   assign rsp_kind            = head.kind;
   assign rsp_payload_byte    = head.payload_byte;
   assign rsp_frame_topic     = head.frame_topic;
   assign rsp_declared_length = head.declared_length;
   assign rsp_status          = head.status;
   assign rsp_truncated       = head.truncated;
   assign rsp_last            = head.last;

endmodule

FILE: sv/fdc_core.sv
// frame state, crc update and result generation for one byte
module fdc_core
   import fdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   output push_type   push
);

   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  topic_ff, topic_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] window_ff, window_in;

   logic [7:0]  topic_cur;
   logic [7:0]  length_cur;
   logic [7:0]  leaving;
   logic [15:0] crc_cur;
   logic [15:0] window_cur;
   logic        data_hit;
   logic        too_long;
   logic        trunc;
   logic [1:0]  status;
   result_type  data_res;
   result_type  sum_res;

   always_comb begin
      topic_cur  = (pos_ff == 9'd0) ? rx_byte : topic_ff;
      length_cur = (pos_ff == 9'd0) ? 8'd0 : ((pos_ff == 9'd1) ? rx_byte : length_ff);
      leaving    = window_ff[15:8];
      crc_cur    = (pos_ff >= 9'd2) ? crc_feed(crc_ff, leaving) : crc_ff;
      window_cur = {window_ff[7:0], rx_byte};
      data_hit   = (pos_ff >= 9'd4) && ({1'b0, pos_ff} < ({2'b00, length_cur} + 10'd4));
      too_long   = (pos_ff >= 9'd255);
      trunc      = !too_long && (({2'b00, length_cur} + 10'd4) > ({1'b0, pos_ff} + 10'd1));
      if (too_long) begin
         status = STATUS_TOO_LONG;
      end else if (pos_ff < 9'd3) begin
         status = STATUS_TOO_SHORT;
      end else if (window_cur != crc_cur) begin
         status = STATUS_CRC_ERR;
      end else begin
         status = STATUS_OK;
      end

      data_res.kind            = KIND_DATA;
      data_res.payload_byte    = leaving;
      data_res.frame_topic     = topic_cur;
      data_res.declared_length = length_cur;
      data_res.status          = STATUS_OK;
      data_res.truncated       = 1'b0;
      data_res.last            = !frame_end;

      sum_res.kind            = KIND_SUMMARY;
      sum_res.payload_byte    = 8'd0;
      sum_res.frame_topic     = topic_cur;
      sum_res.declared_length = length_cur;
      sum_res.status          = status;
      sum_res.truncated       = trunc;
      sum_res.last            = 1'b1;

      push.first_valid  = take && (data_hit || frame_end);
      push.second_valid = take && data_hit && frame_end;
      push.first        = data_hit ? data_res : sum_res;
      push.second       = sum_res;

      pos_in    = pos_ff;
      topic_in  = topic_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      window_in = window_ff;
      if (take) begin
         if (frame_end) begin
            pos_in    = 9'd0;
            topic_in  = 8'd0;
            length_in = 8'd0;
            crc_in    = CRC_INIT;
            window_in = 16'd0;
         end else begin
            pos_in    = (pos_ff != POS_MAX) ? pos_ff + 9'd1 : pos_ff;
            topic_in  = topic_cur;
            length_in = length_cur;
            crc_in    = crc_cur;
            window_in = window_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 9'd0;
         topic_ff  <= 8'd0;
         length_ff <= 8'd0;
         crc_ff    <= CRC_INIT;
         window_ff <= 16'd0;
      end else begin
         pos_ff    <= pos_in;
         topic_ff  <= topic_in;
         length_ff <= length_in;
         crc_ff    <= crc_in;
         window_ff <= window_in;
      end
   end

endmodule

FILE: sv/fdc_checker.sv
// port-level checks for the frame deframer, bound to the top level
`include "frame_deframer_crc16_check_macros.svh"

module fdc_checker
   import fdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [7:0] rsp_payload_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_truncated,
   input logic       rsp_last
);

   `FDC_ASSERT_NEXT(a_idle_after_reset, clock, reset, !rsp_valid && !req_stall)

   `FDC_ASSERT_IMPLY(a_summary_last, clock, reset, rsp_valid && rsp_kind == KIND_SUMMARY, rsp_last && rsp_payload_byte == 8'd0)

   `FDC_ASSERT_IMPLY(a_data_clean, clock, reset, rsp_valid && rsp_kind == KIND_DATA, rsp_status == STATUS_OK && !rsp_truncated)

   `FDC_ASSERT_IMPLY(a_long_not_trunc, clock, reset, rsp_valid && rsp_status == STATUS_TOO_LONG, !rsp_truncated)

   `FDC_ASSERT_IMPLY(a_rsp_held, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid)

endmodule

bind frame_deframer_crc16_check fdc_checker u_fdc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_status       (rsp_status),
   .rsp_truncated    (rsp_truncated),
   .rsp_last         (rsp_last)
);

FILE: tb/frame_deframer_crc16_check_test.sv
// self-checking testbench for the framed packet deframer with crc-16 check
module frame_deframer_crc16_check_test;
   import fdc_pkg::*;

   localparam int IDLE_LIMIT = 500;
   localparam int RANDOM_ITEMS = 1700;

   typedef struct packed {
      logic [7:0] data;
      logic       frame_end;
      logic [3:0] gap;
      logic       drain;
   } rx_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_topic;
   logic [7:0] rsp_declared_length;
   logic [1:0] rsp_status;
   logic       rsp_truncated;
   logic       rsp_last;

   rx_item_type rx_bytes_to_send[$];
   result_type  due_results[$];
   logic [7:0]  frame_buf[$];

   // predictor state
   logic [8:0]  frame_pos = 9'd0;
   logic [7:0]  frame_topic_q = 8'd0;
   logic [7:0]  frame_len_q = 8'd0;
   logic [15:0] running_crc = CRC_INIT;
   logic [15:0] crc_window = 16'd0;

   int item_total = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int data_results = 0;
   int frames_seen = 0;
   int truncated_frames = 0;
   int status_count[4] = '{0, 0, 0, 0};
   int mismatch_count = 0;
   int idle_cycles = 0;
   int send_burst = 0;
   int recv_burst = 0;
   int wait_cycles = 0;
   int stall_left = 0;
   logic drain_next = 1'b0;
   logic send_fire;
   rx_item_type next_item;
   result_type want;

   frame_deframer_crc16_check dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_topic(rsp_frame_topic),
      .rsp_declared_length(rsp_declared_length),
      .rsp_status(rsp_status),
      .rsp_truncated(rsp_truncated),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void predict_frame_byte(input logic [7:0] b, input logic fend);
      result_type r;
      logic [7:0] leaving;
      int         p;
      int         flen;
      p = frame_pos;
      if (p == 0) begin
         frame_topic_q = b;
         frame_len_q = 8'd0;
      end else if (p == 1) begin
         frame_len_q = b;
      end
      if (p >= 2) begin
         leaving = crc_window[15:8];
         running_crc = crc16_ccitt_byte(running_crc, leaving);
         if (p - 2 >= 2 && p - 2 < 2 + int'(frame_len_q)) begin
            r = '0;
            r.kind = KIND_DATA;
            r.payload_byte = leaving;
            r.frame_topic = frame_topic_q;
            r.declared_length = frame_len_q;
            r.status = STATUS_OK;
            r.last = !fend;
            due_results.push_back(r);
            data_results++;
         end
      end
      crc_window = {crc_window[7:0], b};
      if (fend) begin
         flen = p + 1;
         r = '0;
         r.kind = KIND_SUMMARY;
         r.frame_topic = frame_topic_q;
         r.declared_length = frame_len_q;
         r.last = 1'b1;
         if (flen > 255) begin
            r.status = STATUS_TOO_LONG;
         end else begin
            r.truncated = (int'(frame_len_q) + 4 > flen);
            if (flen < 4) begin
               r.status = STATUS_TOO_SHORT;
            end else if (crc_window != running_crc) begin
               r.status = STATUS_CRC_ERR;
            end else begin
               r.status = STATUS_OK;
            end
         end
         due_results.push_back(r);
         frames_seen++;
         status_count[r.status]++;
         if (r.truncated) begin
            truncated_frames++;
         end
         frame_pos = 9'd0;
         frame_topic_q = 8'd0;
         frame_len_q = 8'd0;
         running_crc = CRC_INIT;
         crc_window = 16'd0;
      end else if (frame_pos != POS_MAX) begin
         frame_pos = frame_pos + 9'd1;
      end
   endfunction

   function automatic int next_gap();
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         send_burst = $urandom_range(20, 80);
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic int next_stall();
      if (recv_burst > 0) begin
         recv_burst--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         recv_burst = $urandom_range(20, 80);
      end
      return $urandom_range(0, 9);
   endfunction

   // topic, declared length, data bytes, then big-endian crc
   function automatic void make_frame(input logic [7:0] topic, input logic [7:0] declared,
                                      input int n_data, input logic bad_crc);
      logic [15:0] c;
      frame_buf.delete();
      frame_buf.push_back(topic);
      frame_buf.push_back(declared);
      for (int i = 0; i < n_data; i++) begin
         frame_buf.push_back(8'($urandom));
      end
      c = CRC_INIT;
      foreach (frame_buf[i]) begin
         c = crc16_ccitt_byte(c, frame_buf[i]);
      end
      if (bad_crc) begin
         c = c ^ (16'h0001 << $urandom_range(0, 15));
      end
      frame_buf.push_back(c[15:8]);
      frame_buf.push_back(c[7:0]);
   endfunction

   function automatic void queue_frame();
      rx_item_type it;
      foreach (frame_buf[i]) begin
         it.data = frame_buf[i];
         it.frame_end = (i == frame_buf.size() - 1);
         it.gap = 4'(next_gap());
         it.drain = (i == 0) && drain_next;
         rx_bytes_to_send.push_back(it);
      end
      drain_next = 1'b0;
   endfunction

   function automatic void add_random_frames(input int until_size);
      int pick;
      int declared;
      int n_data;
      while (rx_bytes_to_send.size() < until_size) begin
         pick = $urandom_range(0, 99);
         drain_next = ($urandom_range(0, 29) == 0);
         if (pick < 60) begin
            declared = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                    : $urandom_range(0, 12);
            make_frame(8'($urandom), 8'(declared), declared, 1'b0);
         end else if (pick < 72) begin
            declared = $urandom_range(0, 12);
            make_frame(8'($urandom), 8'(declared), declared, 1'b1);
         end else if (pick < 82) begin
            declared = $urandom_range(1, 255);
            n_data = $urandom_range(0, (declared - 1 < 8) ? declared - 1 : 8);
            make_frame(8'($urandom), 8'(declared), n_data, $urandom_range(0, 3) == 0);
         end else if (pick < 90) begin
            declared = $urandom_range(0, 8);
            make_frame(8'($urandom), 8'(declared), declared + $urandom_range(1, 6),
                       $urandom_range(0, 3) == 0);
         end else begin
            // noise and broken frames, often shorter than a header plus crc
            n_data = $urandom_range(1, 6);
            frame_buf.delete();
            for (int i = 0; i < n_data; i++) begin
               frame_buf.push_back(8'($urandom));
            end
         end
         queue_frame();
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int exp_val);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at result %0d: %s got %0h want %0h",
                  results_checked, field, got, exp_val);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         wait_cycles = 0;
      end else begin
         send_fire = req_valid && !req_stall;
         if (send_fire) begin
            predict_frame_byte(req_rx_byte, req_frame_end);
            items_accepted++;
         end
         if (send_fire || !req_valid) begin
            if (rx_bytes_to_send.size() != 0 && wait_cycles >= rx_bytes_to_send[0].gap &&
                !(rx_bytes_to_send[0].drain && due_results.size() != 0)) begin
               next_item = rx_bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_rx_byte <= next_item.data;
               req_frame_end <= next_item.frame_end;
               wait_cycles = 0;
            end else begin
               req_valid <= 1'b0;
               wait_cycles++;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("item with nothing expected, kind", rsp_kind, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
               if (rsp_frame_topic !== want.frame_topic)
                  report_mismatch("frame_topic", rsp_frame_topic, want.frame_topic);
               if (rsp_declared_length !== want.declared_length)
                  report_mismatch("declared_length", rsp_declared_length,
                                  want.declared_length);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_truncated !== want.truncated)
                  report_mismatch("truncated", rsp_truncated, want.truncated);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
            results_checked++;
            stall_left = next_stall();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d of %0d bytes sent, %0d results still due",
                     items_accepted, item_total, due_results.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      // directed frames
      frame_buf = '{8'hFF};
      queue_frame();
      frame_buf = '{8'h80, 8'h7F};
      queue_frame();
      frame_buf = '{8'h00, 8'h02, 8'h55};
      queue_frame();
      drain_next = 1'b1;
      make_frame(8'hA5, 8'h00, 0, 1'b0);
      queue_frame();
      make_frame(8'h00, 8'h03, 3, 1'b0);
      queue_frame();
      make_frame(8'h5A, 8'h01, 1, 1'b1);
      queue_frame();
      make_frame(8'hFF, 8'hFF, 1, 1'b0);
      queue_frame();

      add_random_frames(400);
      make_frame(8'($urandom), 8'd251, 251, 1'b0);
      queue_frame();
      add_random_frames(800);
      make_frame(8'($urandom), 8'd255, 252, 1'b0);
      queue_frame();
      add_random_frames(1100);
      make_frame(8'($urandom), 8'd255, 526, 1'b0);
      queue_frame();
      add_random_frames(RANDOM_ITEMS);
      item_total = rx_bytes_to_send.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < item_total || due_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);

      $display("sent %0d frames in %0d bytes: %0d ok, %0d crc errors, %0d too short, %0d too long",
               frames_seen, items_accepted, status_count[STATUS_OK],
               status_count[STATUS_CRC_ERR], status_count[STATUS_TOO_SHORT],
               status_count[STATUS_TOO_LONG]);
      $display("checked %0d results (%0d data bytes, %0d truncated frames), %0d mismatches",
               results_checked, data_results, truncated_frames, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
